// File: rtl/core/u8a_pkg.sv
// Package with the types, constants and transliteration table of the UTF-8 to ASCII block.
package u8a_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [6:0] CHAR_UNKNOWN = 7'h3F;
  localparam logic [6:0] CHAR_NUL     = 7'h00;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       string_end;
  } u8a_in_t;

  typedef struct packed {
    logic [6:0] out_char;
    logic       run_last;
    logic       string_done;
  } u8a_out_t;

  typedef struct packed {
    logic [1:0]      cnt;
    logic [2:0][6:0] chars;
  } u8a_xlat_t;

  typedef struct packed {
    u8a_xlat_t xl;
    logic      fin;
  } u8a_entry_t;

  function automatic u8a_xlat_t t0();
    u8a_xlat_t r;
    r = '0;
    return r;
  endfunction

  function automatic u8a_xlat_t t1(input logic [7:0] a);
    u8a_xlat_t r;
    r = '0;
    r.cnt = 2'd1;
    r.chars[0] = a[6:0];
    return r;
  endfunction

  function automatic u8a_xlat_t t2(input logic [7:0] a, input logic [7:0] b);
    u8a_xlat_t r;
    r = '0;
    r.cnt = 2'd2;
    r.chars[0] = a[6:0];
    r.chars[1] = b[6:0];
    return r;
  endfunction

  function automatic u8a_xlat_t t3(input logic [7:0] a, input logic [7:0] b,
                                   input logic [7:0] c);
    u8a_xlat_t r;
    r.cnt = 2'd3;
    r.chars[0] = a[6:0];
    r.chars[1] = b[6:0];
    r.chars[2] = c[6:0];
    return r;
  endfunction

  function automatic u8a_xlat_t xlat(input logic [20:0] cp);
    u8a_xlat_t r;
    r = t1({1'b0, CHAR_UNKNOWN});
    if (cp[20:16] == 5'd0) begin
      unique case (cp[15:0])
        16'h0104: r = t1("A");
        16'h0105: r = t1("a");
        16'h0106: r = t1("C");
        16'h0107: r = t1("c");
        16'h0118: r = t1("E");
        16'h0119: r = t1("e");
        16'h0141: r = t1("L");
        16'h0142: r = t1("l");
        16'h0143: r = t1("N");
        16'h0144: r = t1("n");
        16'h00D3: r = t1("O");
        16'h00F3: r = t1("o");
        16'h015A: r = t1("S");
        16'h015B: r = t1("s");
        16'h0179: r = t1("Z");
        16'h017A: r = t1("z");
        16'h017B: r = t1("Z");
        16'h017C: r = t1("z");
        16'h0410: r = t1("A");
        16'h0430: r = t1("a");
        16'h0411: r = t1("B");
        16'h0431: r = t1("b");
        16'h0412: r = t1("V");
        16'h0432: r = t1("v");
        16'h0413: r = t1("G");
        16'h0433: r = t1("g");
        16'h0414: r = t1("D");
        16'h0434: r = t1("d");
        16'h0415: r = t1("E");
        16'h0435: r = t1("e");
        16'h0401: r = t1("E");
        16'h0451: r = t1("e");
        16'h0416: r = t2("Z", "h");
        16'h0436: r = t2("z", "h");
        16'h0417: r = t1("Z");
        16'h0437: r = t1("z");
        16'h0418: r = t1("I");
        16'h0438: r = t1("i");
        16'h0419: r = t1("J");
        16'h0439: r = t1("j");
        16'h041A: r = t1("K");
        16'h043A: r = t1("k");
        16'h041B: r = t1("L");
        16'h043B: r = t1("l");
        16'h041C: r = t1("M");
        16'h043C: r = t1("m");
        16'h041D: r = t1("N");
        16'h043D: r = t1("n");
        16'h041E: r = t1("O");
        16'h043E: r = t1("o");
        16'h041F: r = t1("P");
        16'h043F: r = t1("p");
        16'h0420: r = t1("R");
        16'h0440: r = t1("r");
        16'h0421: r = t1("S");
        16'h0441: r = t1("s");
        16'h0422: r = t1("T");
        16'h0442: r = t1("t");
        16'h0423: r = t1("U");
        16'h0443: r = t1("u");
        16'h0424: r = t1("F");
        16'h0444: r = t1("f");
        16'h0425: r = t2("K", "h");
        16'h0445: r = t2("k", "h");
        16'h0426: r = t2("T", "s");
        16'h0446: r = t2("t", "s");
        16'h0427: r = t2("C", "h");
        16'h0447: r = t2("c", "h");
        16'h0428: r = t2("S", "h");
        16'h0448: r = t2("s", "h");
        16'h0429: r = t3("S", "c", "h");
        16'h0449: r = t3("s", "c", "h");
        16'h042A: r = t0();
        16'h044A: r = t0();
        16'h042B: r = t1("Y");
        16'h044B: r = t1("y");
        16'h042C: r = t0();
        16'h044C: r = t0();
        16'h042D: r = t1("E");
        16'h044D: r = t1("e");
        16'h042E: r = t2("Y", "u");
        16'h044E: r = t2("y", "u");
        16'h042F: r = t2("Y", "a");
        16'h044F: r = t2("y", "a");
        16'h0404: r = t2("Y", "e");
        16'h0454: r = t2("y", "e");
        16'h0406: r = t1("I");
        16'h0456: r = t1("i");
        16'h0407: r = t2("Y", "i");
        16'h0457: r = t2("y", "i");
        16'h0490: r = t1("G");
        16'h0491: r = t1("g");
        default:  r = t1({1'b0, CHAR_UNKNOWN});
      endcase
    end
    return r;
  endfunction

endpackage

// File: rtl/core/utf8_transliterate_to_ascii.sv
// Top level of the UTF-8 to ASCII transliterator.
// The block takes one UTF-8 byte per transfer and returns ASCII characters, one per output
// transfer. A byte is accepted in the cycle it arrives as long as the four-entry queue between
// the decoder and the serializer has room, so input bytes flow back to back. Each byte yields
// zero to three characters, and the serializer sends one character per cycle while out_ready
// is high, so the sustained rate is set by the output port. The first character of a byte is
// offered once its entry is written into the queue and then loaded into the serializer's
// current-entry register. run_last marks the last character caused by a byte, and string_done
// the final one of a string; a string that ends without a character sends a single NUL with
// both flags set.
module utf8_transliterate_to_ascii (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  u8a_pkg::u8a_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output u8a_pkg::u8a_out_t out_data
);

  logic                push, pop, q_full, q_empty;
  u8a_pkg::u8a_entry_t push_data, pop_data;

  u8a_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  u8a_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  u8a_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (pop_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: rtl/core/u8a_front.sv
// Front end: UTF-8 sequence decoder and code point transliteration.
module u8a_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  u8a_pkg::u8a_in_t    in_data,
  input  logic                q_full,
  output logic                push,
  output u8a_pkg::u8a_entry_t push_data
);

  logic [1:0]  pend_r, pend_nxt;
  logic [20:0] acc_r, acc_nxt;
  logic [1:0]  pend_dec;
  logic [20:0] acc_dec;
  logic        lookup;
  logic        accept;
  logic [7:0]  b;
  logic        fin;
  u8a_pkg::u8a_xlat_t xl;
  u8a_pkg::u8a_xlat_t res;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign b        = in_data.in_byte;
  assign fin      = in_data.string_end;

  always_comb begin
    pend_dec = pend_r;
    acc_dec  = acc_r;
    lookup   = 1'b0;
    res      = u8a_pkg::t0();
    if (pend_r == 2'd0) begin
      if (!b[7]) begin
        res = u8a_pkg::t1(b);
      end else if (b[7:5] == 3'b110) begin
        acc_dec  = {16'd0, b[4:0]};
        pend_dec = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        acc_dec  = {17'd0, b[3:0]};
        pend_dec = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
        acc_dec  = {18'd0, b[2:0]};
        pend_dec = 2'd3;
      end
      lookup = (pend_dec != 2'd0) && fin;
    end else begin
      acc_dec  = {acc_r[14:0], b[5:0]};
      pend_dec = pend_r - 2'd1;
      lookup   = (pend_dec == 2'd0) || fin;
    end
    xl       = u8a_pkg::xlat(acc_dec);
    pend_nxt = pend_dec;
    acc_nxt  = acc_dec;
    if (lookup || fin) begin
      pend_nxt = 2'd0;
      acc_nxt  = '0;
    end
    if (lookup) begin
      res = xl;
    end
    if (fin && res.cnt == 2'd0) begin
      res = u8a_pkg::t1({1'b0, u8a_pkg::CHAR_NUL});
    end
    push_data.xl  = res;
    push_data.fin = fin;
    push          = accept && (res.cnt != 2'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      acc_r  <= '0;
    end else if (accept) begin
      pend_r <= pend_nxt;
      acc_r  <= acc_nxt;
    end
  end

endmodule

// File: rtl/core/u8a_queue.sv
// Short queue of transliterated entries between the decoder and the serializer.
module u8a_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  u8a_pkg::u8a_entry_t push_data,
  input  logic                pop,
  output u8a_pkg::u8a_entry_t pop_data,
  output logic                full,
  output logic                empty
);

  u8a_pkg::u8a_entry_t   mem_r [u8a_pkg::QDEPTH];
  logic [u8a_pkg::QAW-1:0] wp_r, rp_r;
  logic [u8a_pkg::QAW:0]   cnt_r;

  assign full     = (cnt_r == (u8a_pkg::QAW+1)'(u8a_pkg::QDEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (u8a_pkg::QAW+1)'(push) - (u8a_pkg::QAW+1)'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
    else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (u8a_pkg::QAW+1)'(u8a_pkg::QDEPTH))
    else $error("queue count out of range");

endmodule

// File: rtl/core/u8a_back.sv
// Back end: serializes each queued entry into single ASCII characters.
module u8a_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  u8a_pkg::u8a_entry_t q_data,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output u8a_pkg::u8a_out_t   out_data
);

  logic                cur_valid_r, cur_valid_nxt;
  u8a_pkg::u8a_entry_t cur_r, cur_nxt;
  logic [1:0]          idx_r, idx_nxt;
  logic                last;
  logic                xfer;
  logic [6:0]          ch;

  assign last = (idx_r == cur_r.xl.cnt - 2'd1);
  assign xfer = out_valid && out_ready;

  always_comb begin
    case (idx_r)
      2'd0:    ch = cur_r.xl.chars[0];
      2'd1:    ch = cur_r.xl.chars[1];
      default: ch = cur_r.xl.chars[2];
    endcase
  end

  assign out_valid            = cur_valid_r;
  assign out_data.out_char    = ch;
  assign out_data.run_last    = last;
  assign out_data.string_done = last && cur_r.fin;

  always_comb begin
    pop           = !q_empty && (!cur_valid_r || (xfer && last));
    cur_valid_nxt = cur_valid_r;
    cur_nxt       = cur_r;
    idx_nxt       = idx_r;
    if (pop) begin
      cur_valid_nxt = 1'b1;
      cur_nxt       = q_data;
      idx_nxt       = 2'd0;
    end else if (xfer) begin
      if (last) begin
        cur_valid_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> (idx_r < cur_r.xl.cnt))
    else $error("character index beyond entry length");
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(idx_r)))
    else $error("serializer advanced without a transfer");

endmodule
